// ===== src/asrv_pkg.sv =====
// Shared constants and register codes for the envelope vector blend block.
`default_nettype none
package asrv_pkg;

  localparam int DEF_COMPONENTS      = 4;
  localparam int DEF_COMPONENT_WIDTH = 16;
  localparam int DEF_TIME_WIDTH      = 32;

  localparam int MAX_COMPONENTS = 4;
  localparam int OUT_W          = 16;
  localparam int TICK_W         = 16;
  localparam int FRAC_W         = 16;
  localparam int WEIGHT_W       = FRAC_W + 1;
  localparam int TOTAL_W        = TICK_W + 2;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 64;
  localparam int STEP_CNT_W     = $clog2(FRAC_W + 1);

  localparam logic [WEIGHT_W-1:0] FULL_WEIGHT = WEIGHT_W'(1) << FRAC_W;

  localparam logic [CFG_IDX_W-1:0] REG_START_TIME = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET     = 3'd6;

  typedef struct packed {
    logic start;
    logic [WEIGHT_W-1:0] weight;
  } asrv_mul_cmd_t;

endpackage
`default_nettype wire

// ===== src/asrv_div.sv =====
// Bit-serial restoring divider: floor(num * 2^16 / den) for num below den.
`default_nettype none
module asrv_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [asrv_pkg::TICK_W-1:0] num,
  input  wire logic [asrv_pkg::TICK_W-1:0] den,
  output logic                             done,
  output logic [asrv_pkg::FRAC_W-1:0]      quot
);
  import asrv_pkg::*;

  logic [TICK_W-1:0]     rem_r, rem_nxt;
  logic [FRAC_W-1:0]     quot_r, quot_nxt;
  logic [TICK_W-1:0]     den_r, den_nxt;
  logic [STEP_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [TICK_W:0]       shifted;
  logic [TICK_W:0]       diff;
  logic                  fits;

  always_comb begin
    shifted  = {rem_r, 1'b0};
    diff     = shifted - {1'b0, den_r};
    fits     = shifted >= {1'b0, den_r};
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = num;
      den_nxt  = den;
      quot_nxt = '0;
      cnt_nxt  = STEP_CNT_W'(FRAC_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = fits ? diff[TICK_W-1:0] : shifted[TICK_W-1:0];
      quot_nxt = {quot_r[FRAC_W-2:0], fits};
      cnt_nxt  = cnt_r - STEP_CNT_W'(1);
      if (cnt_r == STEP_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
    den_r  <= den_nxt;
    cnt_r  <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule
`default_nettype wire

// ===== src/asrv_mul.sv =====
// Shift-add blend lanes: start + floor((target - start) * weight / 2^16).
`default_nettype none
module asrv_mul #(
  parameter int COMPONENTS      = asrv_pkg::DEF_COMPONENTS,
  parameter int COMPONENT_WIDTH = asrv_pkg::DEF_COMPONENT_WIDTH
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire asrv_pkg::asrv_mul_cmd_t               cmd,
  input  wire logic [COMPONENTS*COMPONENT_WIDTH-1:0] init_vals,
  input  wire logic [COMPONENTS*COMPONENT_WIDTH-1:0] targ_vals,
  output logic                                       done,
  output logic [COMPONENTS*COMPONENT_WIDTH-1:0]      blend_vals
);
  import asrv_pkg::*;

  localparam int CW = COMPONENT_WIDTH;
  localparam int AW = CW + 2;

  logic [FRAC_W-1:0]     wsh_r, wsh_nxt;
  logic                  full_r, full_nxt;
  logic [STEP_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;

  always_comb begin
    wsh_nxt  = wsh_r;
    full_nxt = full_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (cmd.start) begin
      wsh_nxt  = cmd.weight[FRAC_W-1:0];
      full_nxt = cmd.weight[FRAC_W];
      cnt_nxt  = STEP_CNT_W'(FRAC_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      wsh_nxt = wsh_r >> 1;
      cnt_nxt = cnt_r - STEP_CNT_W'(1);
      if (cnt_r == STEP_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    wsh_r  <= wsh_nxt;
    full_r <= full_nxt;
    cnt_r  <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  for (genvar k = 0; k < COMPONENTS; k++) begin : g_lane
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
    logic signed [AW-1:0] d;
    logic signed [AW-1:0] sum;
    logic signed [AW-1:0] acc_r, acc_nxt;
    logic signed [AW-1:0] res;

    always_comb begin
      a   = signed'(init_vals[k*CW +: CW]);
      b   = signed'(targ_vals[k*CW +: CW]);
      d   = AW'(b) - AW'(a);
      sum = acc_r + (wsh_r[0] ? d : AW'(0));
      acc_nxt = acc_r;
      if (cmd.start) begin
        acc_nxt = '0;
      end else if (busy_r) begin
        acc_nxt = sum >>> 1;
      end
      res = full_r ? AW'(b) : AW'(a) + acc_r;
    end

    always_ff @(posedge clk) begin
      acc_r <= acc_nxt;
    end

    assign blend_vals[k*CW +: CW] = res[CW-1:0];
  end

  assign done = done_r;

endmodule
`default_nettype wire

// ===== src/asr_envelope_vector_lerp.sv =====
// Top level: attack-sustain-release envelope that blends a vector of components.
//
//  channel | ports                                  | direction
//  --------+----------------------------------------+----------
//  in      | in_valid, in_ready, in_frame_time       | input item
//  out     | out_valid, out_ready, out_value_0..3,  | result item
//          | out_weight, out_done_res               |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register write
//
// When the weight needs a division an item passes the select state, the bit-serial
// divider, the shift-add multiply lanes and the output load in that order; otherwise
// the divider is skipped. Synchronous active-low reset sets attack and release to 1,
// the other configuration registers to 0, and clears the finished flag. A new item
// is taken while a result waits in the output register; a stalled result holds the
// block in its last step until taken.
`default_nettype none
module asr_envelope_vector_lerp #(
  parameter int COMPONENTS      = asrv_pkg::DEF_COMPONENTS,
  parameter int COMPONENT_WIDTH = asrv_pkg::DEF_COMPONENT_WIDTH,
  parameter int TIME_WIDTH      = asrv_pkg::DEF_TIME_WIDTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [TIME_WIDTH-1:0]           in_frame_time,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic signed [asrv_pkg::OUT_W-1:0]    out_value_0,
  output logic signed [asrv_pkg::OUT_W-1:0]    out_value_1,
  output logic signed [asrv_pkg::OUT_W-1:0]    out_value_2,
  output logic signed [asrv_pkg::OUT_W-1:0]    out_value_3,
  output logic [asrv_pkg::WEIGHT_W-1:0]        out_weight,
  output logic                                 out_done_res,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [asrv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [asrv_pkg::CFG_DATA_W-1:0] cfg_data
);
  import asrv_pkg::*;

  localparam int CW    = COMPONENT_WIDTH;
  localparam int VW    = COMPONENTS * CW;
  localparam int CMP_W = (TIME_WIDTH > TOTAL_W) ? TIME_WIDTH : TOTAL_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SEL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [TIME_WIDTH-1:0] start_time_r;
  logic [TICK_W-1:0]     attack_r, sustain_r, release_r;
  logic                  hold_r;
  logic [CFG_DATA_W-1:0] init_r, targ_r;

  logic [2:0]            state_r, state_nxt;
  logic [TIME_WIDTH-1:0] t_r, t_nxt;
  logic [WEIGHT_W-1:0]   weight_r, weight_nxt;
  logic                  finished_r, finished_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]      out_val_r [MAX_COMPONENTS];
  logic [WEIGHT_W-1:0]   out_weight_r;
  logic                  out_done_r;
  logic                  load_out;

  logic [CMP_W-1:0]      t_ext;
  logic [TOTAL_W-1:0]    total;
  logic [TOTAL_W-1:0]    rel_x;
  logic                  t_ge_att, t_ge_tot;

  logic                  div_start, div_done;
  logic [TICK_W-1:0]     div_num, div_den;
  logic [FRAC_W-1:0]     div_quot;
  asrv_mul_cmd_t         mul_cmd;
  logic                  mul_done;
  logic [VW-1:0]         blend_vals;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_time_r <= '0;
      attack_r     <= TICK_W'(1);
      sustain_r    <= '0;
      release_r    <= TICK_W'(1);
      hold_r       <= 1'b0;
      init_r       <= '0;
      targ_r       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_START_TIME: start_time_r <= cfg_data[TIME_WIDTH-1:0];
        REG_ATTACK:     attack_r     <= cfg_data[TICK_W-1:0];
        REG_SUSTAIN:    sustain_r    <= cfg_data[TICK_W-1:0];
        REG_RELEASE:    release_r    <= cfg_data[TICK_W-1:0];
        REG_HOLD:       hold_r       <= cfg_data[0];
        REG_INITIAL:    init_r       <= cfg_data;
        REG_TARGET:     targ_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    t_ext    = CMP_W'(t_r);
    total    = TOTAL_W'(attack_r) + TOTAL_W'(sustain_r) + TOTAL_W'(release_r);
    rel_x    = total - t_ext[TOTAL_W-1:0];
    t_ge_att = t_ext >= CMP_W'(attack_r);
    t_ge_tot = t_ext >= CMP_W'(total);
    div_den  = (hold_r || !t_ge_att) ? attack_r : release_r;
    div_num  = (hold_r || !t_ge_att) ? t_r[TICK_W-1:0] : rel_x[TICK_W-1:0];

    state_nxt      = state_r;
    t_nxt          = t_r;
    weight_nxt     = weight_r;
    finished_nxt   = finished_r;
    div_start      = 1'b0;
    mul_cmd.start  = 1'b0;
    mul_cmd.weight = weight_r;
    load_out       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          t_nxt     = (in_frame_time > start_time_r) ? in_frame_time - start_time_r : '0;
          state_nxt = S_SEL;
        end
      end
      S_SEL: begin
        state_nxt  = S_MUL;
        weight_nxt = '0;
        if (finished_r) begin
          weight_nxt = '0;
        end else if (hold_r) begin
          if (t_ge_att) begin
            weight_nxt = FULL_WEIGHT;
          end else begin
            div_start = 1'b1;
          end
        end else if (t_ge_tot) begin
          finished_nxt = 1'b1;
        end else if (!t_ge_att) begin
          div_start = 1'b1;
        end else if (release_r == '0 || rel_x >= TOTAL_W'(release_r)) begin
          weight_nxt = FULL_WEIGHT;
        end else begin
          div_start = 1'b1;
        end
        if (div_start) begin
          state_nxt = S_DIV;
        end else begin
          mul_cmd.start  = 1'b1;
          mul_cmd.weight = weight_nxt;
        end
      end
      S_DIV: begin
        if (div_done) begin
          weight_nxt     = {1'b0, div_quot};
          mul_cmd.start  = 1'b1;
          mul_cmd.weight = weight_nxt;
          state_nxt      = S_MUL;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    t_r      <= t_nxt;
    weight_r <= weight_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      finished_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      finished_r  <= finished_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_weight_r <= weight_r;
      out_done_r   <= finished_r;
      for (int k = 0; k < MAX_COMPONENTS; k++) begin
        if (k < COMPONENTS) begin
          out_val_r[k] <= OUT_W'(signed'(blend_vals[k*CW +: CW]));
        end else begin
          out_val_r[k] <= '0;
        end
      end
    end
  end

  asrv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  asrv_mul #(
    .COMPONENTS      (COMPONENTS),
    .COMPONENT_WIDTH (COMPONENT_WIDTH)
  ) u_mul (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (mul_cmd),
    .init_vals  (init_r[VW-1:0]),
    .targ_vals  (targ_r[VW-1:0]),
    .done       (mul_done),
    .blend_vals (blend_vals)
  );

  assign out_valid    = out_valid_r;
  assign out_value_0  = signed'(out_val_r[0]);
  assign out_value_1  = signed'(out_val_r[1]);
  assign out_value_2  = signed'(out_val_r[2]);
  assign out_value_3  = signed'(out_val_r[3]);
  assign out_weight   = out_weight_r;
  assign out_done_res = out_done_r;

endmodule
`default_nettype wire

// ===== tb/sv/tb_asr_envelope_vector_lerp.sv =====
// Self-checking testbench for the attack-sustain-release vector blend envelope.
`default_nettype none
module tb_asr_envelope_vector_lerp;
  timeunit 1ns;
  timeprecision 1ps;

  import asrv_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [63:0] TIME_MAX = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [3:0][15:0] val;
    logic [16:0]      weight;
    logic             done;
  } frame_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [31:0]           in_frame_time;
  logic                  out_valid;
  logic                  out_ready;
  logic signed [15:0]    out_value_0;
  logic signed [15:0]    out_value_1;
  logic signed [15:0]    out_value_2;
  logic signed [15:0]    out_value_3;
  logic [16:0]           out_weight;
  logic                  out_done_res;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic [31:0] env_start;
  logic [15:0] env_attack;
  logic [15:0] env_sustain;
  logic [15:0] env_release;
  logic        env_hold;
  logic [63:0] env_initial;
  logic [63:0] env_target;
  logic        env_finished;

  frame_result_t pending_frames[$];
  int            fail_count;
  int            result_count;
  int            cycle_count;
  bit            no_idle;

  asr_envelope_vector_lerp dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_frame_time (in_frame_time),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_value_0   (out_value_0),
    .out_value_1   (out_value_1),
    .out_value_2   (out_value_2),
    .out_value_3   (out_value_3),
    .out_weight    (out_weight),
    .out_done_res  (out_done_res),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic predict_envelope(input logic [31:0] frame_time);
    frame_result_t res;
    logic [63:0]   t;
    logic [63:0]   total;
    logic [63:0]   w;
    longint        a_v;
    longint        b_v;
    longint        prod;
    longint        v;
    t = (frame_time > env_start) ? 64'(frame_time - env_start) : 64'd0;
    w = 64'd0;
    if (!env_finished) begin
      if (env_hold) begin
        if (t >= 64'(env_attack)) w = 64'(FULL_WEIGHT);
        else w = (t << 16) / 64'(env_attack);
      end else begin
        total = 64'(env_attack) + 64'(env_sustain) + 64'(env_release);
        if (t >= total) begin
          env_finished = 1'b1;
        end else if (t < 64'(env_attack)) begin
          w = (t << 16) / 64'(env_attack);
        end else if (env_release == 16'd0) begin
          w = 64'(FULL_WEIGHT);
        end else begin
          w = ((total - t) << 16) / 64'(env_release);
          if (w > 64'(FULL_WEIGHT)) w = 64'(FULL_WEIGHT);
        end
      end
    end
    for (int k = 0; k < 4; k++) begin
      a_v = longint'($signed(env_initial[16*k +: 16]));
      b_v = longint'($signed(env_target[16*k +: 16]));
      prod = (b_v - a_v) * longint'(w);
      v = a_v + (prod >>> 16);
      res.val[k] = v[15:0];
    end
    res.weight = w[16:0];
    res.done = env_finished;
    pending_frames.push_back(res);
  endtask

  task automatic send_frame(input logic [31:0] frame_time);
    int gap;
    gap = no_idle ? 0 : $urandom_range(17, 0);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_frame_time <= frame_time;
    do @(posedge clk); while (!in_ready);
    predict_envelope(frame_time);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_START_TIME: env_start = data[31:0];
      REG_ATTACK:     env_attack = data[15:0];
      REG_SUSTAIN:    env_sustain = data[15:0];
      REG_RELEASE:    env_release = data[15:0];
      REG_HOLD:       env_hold = data[0];
      REG_INITIAL:    env_initial = data;
      REG_TARGET:     env_target = data;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [31:0] start_time, input logic [15:0] attack,
                           input logic [15:0] sustain, input logic [15:0] release_len,
                           input logic hold, input logic [63:0] initial_vals,
                           input logic [63:0] target_vals);
    wait_drained();
    write_reg(REG_START_TIME, 64'(start_time));
    write_reg(REG_ATTACK, 64'(attack));
    write_reg(REG_SUSTAIN, 64'(sustain));
    write_reg(REG_RELEASE, 64'(release_len));
    write_reg(REG_HOLD, 64'(hold));
    write_reg(REG_INITIAL, initial_vals);
    write_reg(REG_TARGET, target_vals);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    frame_result_t got;
    frame_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got.val = {out_value_3, out_value_2, out_value_1, out_value_0};
      got.weight = out_weight;
      got.done = out_done_res;
      if (pending_frames.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: v=%0d,%0d,%0d,%0d w=%0d done=%0b",
                   $signed(got.val[0]), $signed(got.val[1]), $signed(got.val[2]),
                   $signed(got.val[3]), got.weight, got.done);
      end else begin
        want = pending_frames.pop_front();
        if (got.val[0] !== want.val[0] || got.val[1] !== want.val[1] ||
            got.val[2] !== want.val[2] || got.val[3] !== want.val[3] ||
            got.weight !== want.weight || got.done !== want.done) begin
          fail_count++;
          if (fail_count <= 10)
            $display("item %0d mismatch: exp v=%0d,%0d,%0d,%0d w=%0d done=%0b got v=%0d,%0d,%0d,%0d w=%0d done=%0b",
                     result_count,
                     $signed(want.val[0]), $signed(want.val[1]), $signed(want.val[2]),
                     $signed(want.val[3]), want.weight, want.done,
                     $signed(got.val[0]), $signed(got.val[1]), $signed(got.val[2]),
                     $signed(got.val[3]), got.weight, got.done);
        end
      end
      result_count++;
    end
  end

  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      gap = no_idle ? 0 : $urandom_range(17, 0);
      @(negedge clk);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic logic [15:0] pick_ticks(input bit allow_zero);
    case ($urandom_range(11, 0))
      0:       return allow_zero ? 16'd0 : 16'd1;
      1:       return 16'd1;
      2:       return 16'hFFFF;
      3, 4, 5, 6, 7: return 16'($urandom_range(40, 1));
      default: return 16'($urandom_range(65535, 1));
    endcase
  endfunction

  function automatic logic [63:0] pick_vector();
    case ($urandom_range(7, 0))
      0:       return 64'h8000_8000_8000_8000;
      1:       return 64'h7FFF_7FFF_7FFF_7FFF;
      2:       return 64'h7FFF_8000_0000_FFFF;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_random_frame();
    logic [63:0] total;
    logic [63:0] room;
    logic [63:0] t;
    logic [31:0] frame_time;
    int          sel;
    total = 64'(env_attack) + 64'(env_sustain) + 64'(env_release);
    room = TIME_MAX - 64'(env_start);
    sel = $urandom_range(15, 0);
    if (sel == 0 && env_start != 0) begin
      frame_time = $urandom_range(env_start, 0);
    end else begin
      if (env_hold) begin
        if (sel < 6) t = 64'($urandom_range(32'(env_attack) + 2, 0));
        else if (sel < 10) t = 64'($urandom);
        else t = 64'($urandom_range(32'(total), 0));
      end else begin
        case (sel)
          1:       t = (env_attack == 0) ? 64'd0 : 64'(env_attack) - 1;
          2:       t = 64'(env_attack);
          3:       t = 64'(env_attack) + 64'(env_sustain);
          4:       t = total - 1;
          default: t = 64'($urandom_range(32'(total - 1), 0));
        endcase
        if (t >= total) t = total - 1;
      end
      if (t > room) t = room;
      frame_time = env_start + t[31:0];
    end
    send_frame(frame_time);
  endtask

  task automatic test_reset_defaults();
    send_frame(32'd0);
    send_frame(32'd1);
    send_frame(32'd0);
  endtask

  task automatic test_ramp_segments();
    configure(32'd1000, 16'd100, 16'd50, 16'd200, 1'b0,
              64'hFFFF_0000_7FFF_8000, 64'h0001_007B_8000_7FFF);
    send_frame(32'd0);
    send_frame(32'd999);
    send_frame(32'd1000);
    send_frame(32'd1001);
    send_frame(32'd1050);
    send_frame(32'd1099);
    send_frame(32'd1100);
    send_frame(32'd1149);
    send_frame(32'd1150);
    send_frame(32'd1151);
    send_frame(32'd1300);
    send_frame(32'd1349);
  endtask

  task automatic test_zero_ramps();
    configure(32'hFFFF_FFF0, 16'd0, 16'd5, 16'd0, 1'b0,
              64'h1234_8000_7FFF_0000, 64'hEDCB_7FFF_8000_FFFF);
    send_frame(32'hFFFF_FFF0);
    send_frame(32'hFFFF_FFF4);
    send_frame(32'h0000_0005);
    configure(32'd0, 16'd0, 16'd0, 16'd0, 1'b1,
              64'h8000_8000_8000_8000, 64'h7FFF_7FFF_7FFF_7FFF);
    send_frame(32'd0);
    send_frame(32'hFFFF_FFFF);
    configure(32'h8000_0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
              64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000);
    send_frame(32'h8000_7FFF);
    send_frame(32'hFFFF_FFFF);
    send_frame(32'h7FFF_FFFF);
  endtask

  task automatic test_random_envelopes();
    logic [31:0] start_time;
    logic [15:0] attack;
    logic [15:0] sustain;
    logic [15:0] release_len;
    logic        hold;
    for (int phase = 0; phase < 20; phase++) begin
      case ($urandom_range(5, 0))
        0:       start_time = 32'd0;
        1:       start_time = 32'hFFFF_FFFF - $urandom_range(300, 0);
        2:       start_time = $urandom_range(100, 0);
        default: start_time = $urandom;
      endcase
      hold = ($urandom_range(3, 0) == 0);
      attack = pick_ticks(1'b1);
      sustain = pick_ticks(1'b1);
      release_len = pick_ticks(1'b1);
      if (!hold && attack == 0 && sustain == 0 && release_len == 0) sustain = 16'd1;
      configure(start_time, attack, sustain, release_len, hold, pick_vector(), pick_vector());
      no_idle = ($urandom_range(4, 0) == 0);
      for (int n = 0; n < 26; n++) begin
        if (n == 13 && phase % 5 == 2) wait_drained();
        send_random_frame();
      end
      no_idle = 1'b0;
    end
  endtask

  task automatic test_finish_sticky();
    configure(32'h10, 16'd3, 16'd2, 16'd4, 1'b0,
              64'h0102_F0F0_8000_7FFF, 64'h7FFF_0F0F_7FFF_8000);
    send_frame(32'h14);
    send_frame(32'h19);
    send_frame(32'h10);
    send_frame(32'hFFFF_FFFF);
    configure(32'd0, 16'd0, 16'd0, 16'd0, 1'b1,
              64'hA5A5_5A5A_8000_7FFF, 64'h5A5A_A5A5_7FFF_8000);
    send_frame(32'd0);
    send_frame(32'd12345);
    configure(32'd500, 16'd20, 16'd10, 16'd30, 1'b0,
              64'h0000_0001_FFFF_8000, 64'h7FFF_8000_0001_0000);
    send_frame(32'd0);
    send_frame(32'd510);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_frame_time = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    fail_count = 0;
    result_count = 0;
    cycle_count = 0;
    no_idle = 1'b0;
    env_start = '0;
    env_attack = 16'd1;
    env_sustain = '0;
    env_release = 16'd1;
    env_hold = 1'b0;
    env_initial = '0;
    env_target = '0;
    env_finished = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_ramp_segments();
    test_zero_ramps();
    test_random_envelopes();
    test_finish_sticky();
    wait_drained();

    if (fail_count == 0 && pending_frames.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
